/* design/dtn_pkg.sv */
// Shared types, constants and cathode table for the decimal to nixie cathode mapper.
`timescale 1ns / 1ps
package dtn_pkg;

  localparam int unsigned ValueW   = 20;
  localparam int unsigned HalfW    = 10;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned NumPos   = 6;
  localparam int unsigned NumDigit = 10;
  localparam int unsigned WordW    = 64;
  localparam int unsigned PosW     = 6;
  localparam int unsigned RowW     = 3;

  localparam logic [ValueW-1:0] MaxShown = 20'd999999;
  localparam logic [DigitW-1:0] DigitMax = 4'd9;

  // driver output number for each table row and digit
  localparam logic [PosW-1:0] CATHODE_MAP [NumPos][NumDigit] = '{
    '{6'd24, 6'd25, 6'd26, 6'd27, 6'd20, 6'd21, 6'd22, 6'd23, 6'd16, 6'd17},
    '{6'd18, 6'd19, 6'd12, 6'd13, 6'd14, 6'd15, 6'd8,  6'd9,  6'd10, 6'd11},
    '{6'd4,  6'd5,  6'd6,  6'd7,  6'd0,  6'd1,  6'd2,  6'd3,  6'd60, 6'd61},
    '{6'd62, 6'd63, 6'd56, 6'd57, 6'd58, 6'd59, 6'd52, 6'd53, 6'd54, 6'd55},
    '{6'd48, 6'd49, 6'd50, 6'd51, 6'd44, 6'd45, 6'd46, 6'd47, 6'd40, 6'd41},
    '{6'd42, 6'd43, 6'd36, 6'd37, 6'd38, 6'd39, 6'd32, 6'd33, 6'd34, 6'd35}
  };

  // table row used by each digit position, most significant first;
  // tens and ones are swapped on the board
  localparam logic [RowW-1:0] ROW_OF_POS [NumPos] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd4
  };

  // value split at the thousands
  typedef struct packed {
    logic [HalfW-1:0] thousands;
    logic [HalfW-1:0] units;
    logic             oor;
  } split_t;

  // six decimal digits, index 0 is the hundred-thousands
  typedef struct packed {
    logic [NumPos-1:0][DigitW-1:0] digit;
    logic                          oor;
  } digits_t;

  function automatic logic [WordW-1:0] cathode_onehot(
    input logic [RowW-1:0]   row,
    input logic [DigitW-1:0] digit
  );
    logic [WordW-1:0] bit_w;
    bit_w = '0;
    if (digit <= DigitMax) begin
      bit_w = {{(WordW-1){1'b0}}, 1'b1} << CATHODE_MAP[row][digit];
    end
    return bit_w;
  endfunction

endpackage

/* design/decimal_to_nixie_cathode_map.sv */
// Top level: six-digit binary to nixie cathode word mapper, streaming in and out.
//
//   channel  dir  handshake                    payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  tdata[19:0] value, [23:20] zero
//   m_axis   out  m_axis_tvalid/m_axis_tready  tdata[31:0] cathodes_low,
//                                              tdata[63:32] cathodes_high,
//                                              tuser out_of_range
//
// Seven register stages: two for the split at the thousands (reciprocal
// multiply plus one correction), four for hundreds/tens/ones of both halves,
// one for the table lookup, which is also the output register.
// One transaction per cycle sustained while m_axis_tready stays high.
// Reset clears only the valid bits; the block then takes input at once.
// Each stage holds while the next is full and stalled, so bubbles close up
// and tready only drops once every stage is occupied.
`timescale 1ns / 1ps
module decimal_to_nixie_cathode_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [19:0] value, [23:20] unused
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] cathodes_low, [63:32] cathodes_high
  output logic        m_axis_tuser    // [0] out_of_range
);
  import dtn_pkg::*;

  logic             split_vld, split_rdy;
  split_t           split;
  logic             dig_vld, dig_rdy;
  digits_t          digits;
  logic [WordW-1:0] word;

  // value -> thousands / remainder
  dtn_div1000 u_div1000 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .value_i (s_axis_tdata[ValueW-1:0]),
    .valid_o (split_vld),
    .ready_i (split_rdy),
    .split_o (split)
  );

  // both halves -> six digits
  dtn_digits u_digits (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (split_vld),
    .ready_o  (split_rdy),
    .split_i  (split),
    .valid_o  (dig_vld),
    .ready_i  (dig_rdy),
    .digits_o (digits)
  );

  // digits -> cathode word, output register
  dtn_encode u_encode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dig_vld),
    .ready_o  (dig_rdy),
    .digits_i (digits),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .word_o   (word),
    .oor_o    (m_axis_tuser)
  );

  assign m_axis_tdata = word;

endmodule

/* design/dtn_div1000.sv */
// Two-stage split of the binary value into thousands and remainder.
`timescale 1ns / 1ps
module dtn_div1000 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [dtn_pkg::ValueW-1:0]      value_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output dtn_pkg::split_t                 split_o
);
  import dtn_pkg::*;

  logic              vld1_q, vld2_q;
  logic              rdy1, rdy2;
  logic [ValueW-1:0] val1_q;
  logic [10:0]       qe1_q, qe1_d;
  logic              oor1_q;
  logic [30:0]       prod1;
  logic [20:0]       prod2;
  logic [20:0]       diff;
  logic [10:0]       rem11;
  split_t            split_q, split_d;

  assign rdy2    = ~vld2_q | ready_i;
  assign rdy1    = ~vld1_q | rdy2;
  assign ready_o = rdy1;
  assign valid_o = vld2_q;
  assign split_o = split_q;

  // estimate of value / 1000, low by at most one
  assign prod1 = {11'd0, value_i} * 31'd1048;
  assign qe1_d = prod1[30:20];

  always_comb begin
    prod2 = {10'd0, qe1_q} * 21'd1000;
    diff  = {1'b0, val1_q} - prod2;
    rem11 = diff[10:0];
    split_d.oor = oor1_q;
    if (rem11 >= 11'd1000) begin
      split_d.thousands = HalfW'(qe1_q + 11'd1);
      split_d.units     = HalfW'(rem11 - 11'd1000);
    end else begin
      split_d.thousands = qe1_q[HalfW-1:0];
      split_d.units     = rem11[HalfW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= valid_i;
      if (rdy2) vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      val1_q <= value_i;
      qe1_q  <= qe1_d;
      oor1_q <= value_i > MaxShown;
    end
    if (rdy2 && vld1_q) begin
      split_q <= split_d;
    end
  end

endmodule

/* design/dtn_digits.sv */
// Four-stage split of both three-digit halves into decimal digits.
`timescale 1ns / 1ps
module dtn_digits (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  dtn_pkg::split_t  split_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dtn_pkg::digits_t digits_o
);
  import dtn_pkg::*;

  localparam int unsigned Lanes = 2;

  logic [3:0]       vld_q;
  logic [3:0]       rdy;
  logic [HalfW-1:0] x_in [Lanes];

  logic [DigitW-1:0] h1_q [Lanes];
  logic [HalfW-1:0]  x1_q [Lanes];
  logic [DigitW-1:0] h2_q [Lanes];
  logic [6:0]        rem2_q [Lanes];
  logic [DigitW-1:0] h3_q [Lanes];
  logic [6:0]        rem3_q [Lanes];
  logic [DigitW-1:0] t3_q [Lanes];
  logic              oor_q [3];
  digits_t           digits_q;

  logic [15:0] hprod [Lanes];
  logic [10:0] hsub  [Lanes];
  logic [14:0] tprod [Lanes];
  logic [6:0]  osub  [Lanes];

  assign rdy[3] = ~vld_q[3] | ready_i;
  assign rdy[2] = ~vld_q[2] | rdy[3];
  assign rdy[1] = ~vld_q[1] | rdy[2];
  assign rdy[0] = ~vld_q[0] | rdy[1];
  assign ready_o  = rdy[0];
  assign valid_o  = vld_q[3];
  assign digits_o = digits_q;

  assign x_in[0] = split_i.thousands;
  assign x_in[1] = split_i.units;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      // hundreds: x * 41 / 4096 is exact below 1024
      hprod[l] = {6'd0, x_in[l]} * 16'd41;
      hsub[l]  = {1'b0, x1_q[l]} - ({7'd0, h1_q[l]} * 11'd100);
      // tens: rem * 205 / 2048 is exact below 100
      tprod[l] = {8'd0, rem2_q[l]} * 15'd205;
      osub[l]  = rem3_q[l] - ({3'd0, t3_q[l]} * 7'd10);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) oor_q[0] <= split_i.oor;
    if (rdy[1] && vld_q[0]) oor_q[1] <= oor_q[0];
    if (rdy[2] && vld_q[1]) oor_q[2] <= oor_q[1];
    if (rdy[3] && vld_q[2]) digits_q.oor <= oor_q[2];
    for (int l = 0; l < Lanes; l++) begin
      if (rdy[0] && valid_i) begin
        x1_q[l] <= x_in[l];
        h1_q[l] <= hprod[l][15:12];
      end
      if (rdy[1] && vld_q[0]) begin
        h2_q[l]   <= h1_q[l];
        rem2_q[l] <= hsub[l][6:0];
      end
      if (rdy[2] && vld_q[1]) begin
        h3_q[l]   <= h2_q[l];
        rem3_q[l] <= rem2_q[l];
        t3_q[l]   <= tprod[l][14:11];
      end
      if (rdy[3] && vld_q[2]) begin
        digits_q.digit[3*l]   <= h3_q[l];
        digits_q.digit[3*l+1] <= t3_q[l];
        digits_q.digit[3*l+2] <= osub[l][DigitW-1:0];
      end
    end
  end

endmodule

/* design/dtn_encode.sv */
// Output stage: table lookup of six digits into the 64-bit cathode word.
`timescale 1ns / 1ps
module dtn_encode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  dtn_pkg::digits_t            digits_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [dtn_pkg::WordW-1:0]   word_o,
  output logic                        oor_o
);
  import dtn_pkg::*;

  logic             vld_q;
  logic [WordW-1:0] word_q, word_d;
  logic             oor_q;

  assign ready_o = ~vld_q | ready_i;
  assign valid_o = vld_q;
  assign word_o  = word_q;
  assign oor_o   = oor_q;

  always_comb begin
    word_d = '0;
    for (int p = 0; p < NumPos; p++) begin
      word_d = word_d | cathode_onehot(ROW_OF_POS[p], digits_i.digit[p]);
    end
    // nothing lit above range
    if (digits_i.oor) word_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
      oor_q  <= digits_i.oor;
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench for the six-digit decimal to nixie cathode mapper: streamed values, predicted words.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom  = 1100;
  localparam int unsigned TailCycles = 24;  // pipeline is seven deep
  localparam int unsigned HoldCycles = 90;
  localparam int unsigned ValueMax   = 1048575;
  localparam int unsigned ShownMax   = 999999;

  // driver output number per table row and digit
  localparam int unsigned PIN_OF_DIGIT [6][10] = '{
    '{24, 25, 26, 27, 20, 21, 22, 23, 16, 17},
    '{18, 19, 12, 13, 14, 15,  8,  9, 10, 11},
    '{ 4,  5,  6,  7,  0,  1,  2,  3, 60, 61},
    '{62, 63, 56, 57, 58, 59, 52, 53, 54, 55},
    '{48, 49, 50, 51, 44, 45, 46, 47, 40, 41},
    '{42, 43, 36, 37, 38, 39, 32, 33, 34, 35}
  };
  // table row per digit position, hundred-thousands first; tens and ones swapped
  localparam int unsigned ROW_OF_DIGIT_POS [6] = '{0, 1, 2, 3, 5, 4};
  localparam int unsigned DIVISOR [6] = '{100000, 10000, 1000, 100, 10, 1};
  localparam int unsigned HOLD_AT [2] = '{300, 800};

  typedef struct packed {
    logic [31:0] cath_lo;
    logic [31:0] cath_hi;
    logic        oor;
  } cathode_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // [19:0] value, [23:20] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;       // [31:0] cathodes_low, [63:32] cathodes_high
  logic        m_tuser;       // [0] out_of_range

  logic [19:0]   value_q [$];
  cathode_word_t cathode_exp_q [$];

  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned oor_cnt      = 0;
  int unsigned error_cnt    = 0;
  int unsigned cycle_cnt    = 0;

  decimal_to_nixie_cathode_map dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic cathode_word_t map_to_cathodes(input logic [19:0] value);
    cathode_word_t res;
    logic [63:0]   word;
    int unsigned   v;
    int unsigned   digit;
    word = '0;
    v    = {12'd0, value};
    res.oor = (v > ShownMax);
    if (!res.oor) begin
      for (int p = 0; p < 6; p++) begin
        digit = (v / DIVISOR[p]) % 10;
        word  = word | (64'd1 << PIN_OF_DIGIT[ROW_OF_DIGIT_POS[p]][digit]);
      end
    end
    res.cath_lo = word[31:0];
    res.cath_hi = word[63:32];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    error_cnt++;
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
  endtask

  // sender: bursts of random length separated by random gaps
  int unsigned sent_idx   = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : sender
    bit took;
    bit free;
    if (rst_ni) begin
      took = s_tvalid && (accepted_cnt > sent_idx);
      if (took) sent_idx++;
      free = !s_tvalid || took;
      if (free) begin
        if (sent_idx < value_q.size() && gap_left == 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0000, value_q[sent_idx]};
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          s_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver: random stall modes, plus two long hold-offs to fill the pipeline
  int unsigned hold_left = 0;
  int unsigned hold_idx  = 0;
  int unsigned mode_left = 0;
  int unsigned rx_mode   = 0;
  int unsigned rx_tick   = 0;

  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      rx_tick++;
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_idx < 2 && accepted_cnt >= HOLD_AT[hold_idx]) begin
        m_tready  <= 1'b0;
        hold_left = HoldCycles - 1;
        hold_idx++;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_tick % 5 != 0);
        endcase
      end
    end
  end

  // monitor: predict on input transactions, check on output transactions
  always @(posedge clk_i) begin : monitor
    cathode_word_t got;
    cathode_word_t want;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        cathode_exp_q.push_back(map_to_cathodes(s_tdata[19:0]));
        accepted_cnt++;
      end
      if (m_tvalid && m_tready) begin
        got.cath_lo = m_tdata[31:0];
        got.cath_hi = m_tdata[63:32];
        got.oor     = m_tuser;
        if (cathode_exp_q.size() == 0) begin
          report_mismatch("unexpected result", '0, m_tdata);
        end else begin
          want = cathode_exp_q.pop_front();
          checked_cnt++;
          if (want.oor) oor_cnt++;
          if (got.cath_lo !== want.cath_lo)
            report_mismatch("cathodes_low", {32'd0, want.cath_lo}, {32'd0, got.cath_lo});
          if (got.cath_hi !== want.cath_hi)
            report_mismatch("cathodes_high", {32'd0, want.cath_hi}, {32'd0, got.cath_hi});
          if (got.oor !== want.oor)
            report_mismatch("out_of_range", {63'd0, want.oor}, {63'd0, got.oor});
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : main
    int unsigned pick;
    // directed: extremes, every digit in every position, tens/ones swap, range edge
    value_q.push_back(20'd0);
    value_q.push_back(20'd1);
    value_q.push_back(20'd9);
    value_q.push_back(20'd10);
    value_q.push_back(20'd90);
    value_q.push_back(20'd100);
    for (int d = 1; d <= 9; d++) value_q.push_back(20'(111111 * d));
    value_q.push_back(20'd123456);
    value_q.push_back(20'd654321);
    value_q.push_back(20'd500000);
    value_q.push_back(20'd999998);
    value_q.push_back(20'd999999);
    value_q.push_back(20'd1000000);
    value_q.push_back(20'd1000001);
    value_q.push_back(20'(ValueMax));
    // random: mostly shown values, some near the range edge, some anywhere
    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        value_q.push_back(20'($urandom_range(0, ShownMax)));
      else if (pick == 7)
        value_q.push_back(20'($urandom_range(ShownMax - 12, ShownMax + 12)));
      else
        value_q.push_back(20'($urandom_range(0, ValueMax)));
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < value_q.size()) @(posedge clk_i);
    while (cathode_exp_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d values streamed, %0d results checked (%0d above range)",
             value_q.size(), checked_cnt, oor_cnt);
    $display("bursty input, random output stalls, two long hold-offs; %0d mismatches",
             error_cnt);
    if (error_cnt == 0 && cathode_exp_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/dtn_pkg.sv
design/dtn_div1000.sv
design/dtn_digits.sv
design/dtn_encode.sv
design/decimal_to_nixie_cathode_map.sv
verif/tb_top.sv
